// ===== hw/rtl/matrix3_inverse_defines.svh =====
// Assertion macros for the 3x3 matrix inverse block.
// Used by the checker; needs a clk and rst in the scope of each use.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// Same-cycle implication, off while in reset
`define MI3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi3 check failed");

// Next-cycle implication, off while in reset
`define MI3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mi3 check failed");

// Next-cycle implication that also watches reset itself
`define MI3_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mi3 check failed");

`endif

// ===== hw/rtl/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies.
package mi3_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int N_EL          = 9;
  localparam int TDATA_W       = N_EL * DATA_W;
  localparam int PROD_W        = 2 * DATA_W;      // 32x32 product
  localparam int COF_W         = PROD_W + 1;      // difference of two products
  localparam int CABS_W        = PROD_W;          // |cofactor| <= 2^63
  localparam int SPLIT         = 33;              // cofactor split for det products
  localparam int DET_W         = 98;              // |det| < 3*2^94
  localparam int DMAG_W        = DET_W - 1;
  localparam int QB            = 33;              // quotient bits kept
  localparam int FRONT_LAT     = 6;
  localparam int LANE_LAT      = QB + 3;
  localparam int TOT_LAT       = FRONT_LAT + LANE_LAT;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [DMAG_W-1:0]        dmag_t;
  typedef logic [CABS_W-1:0]        cabs_t;
  typedef logic [DATA_W-1:0]        thr_t;
  typedef logic [QB-1:0]            quo_t;

  // rows/columns left over when one is struck out
  localparam int OTHER_IDX [3][2] = '{'{1, 2}, '{0, 2}, '{0, 1}};

endpackage

// ===== hw/rtl/matrix3_inverse.sv =====
// Top level of the 3x3 matrix inverse: front pipeline, nine division lanes,
// merge of the singular pass-through and an output skid stage. Uses mi3_pkg.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: 9 x Q16.16 matrix elements
//  m_axis    out  m_axis_tvalid/tready      tdata: 9 x inverse elements, tuser: singular
//  cfg       in   cfg_valid/cfg_ready       cfg_data: singular_threshold
//
// One matrix accepted per cycle while the skid stage is empty. Path from the
// accepting edge to m_axis_tvalid: 6 front stages, 36 lane stages (33 one-bit steps of
// the restoring divider plus 3), then the output register.
// Synchronous reset clears the valid line, the output and skid stages, and
// sets the threshold to 1. Config is taken every cycle (cfg_ready held high).
// A stalled output parks one item in the skid stage; s_axis_tready then drops
// and the whole pipeline holds until the skid drains.
module matrix3_inverse #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (32 bits each)
  input  logic [mi3_pkg::TDATA_W-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (32 bits each)
  output logic [mi3_pkg::TDATA_W-1:0] m_axis_tdata,
  // singular
  output logic [0:0]                  m_axis_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mi3_pkg::DATA_W-1:0]  cfg_data
);
  import mi3_pkg::*;

  thr_t  thr;
  logic  adv;
  logic  vld [TOT_LAT];

  elem_t f_a    [N_EL];
  cabs_t f_cabs [N_EL];
  logic  f_cneg [N_EL];
  dmag_t f_dmag;
  logic  f_dneg;
  logic  f_sing;
  elem_t res    [N_EL];

  elem_t sb_a [LANE_LAT][N_EL];
  logic  sb_s [LANE_LAT];

  logic               x_valid;
  logic [TDATA_W-1:0] x_data;
  logic               out_valid;
  logic [TDATA_W-1:0] out_data;
  logic               out_user;
  logic               skid_valid;
  logic [TDATA_W-1:0] skid_data;
  logic               skid_user;

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= thr_t'(1);
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // pipeline moves whenever the skid stage is free
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TOT_LAT; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < TOT_LAT; k++) vld[k] <= vld[k-1];
    end
  end

  mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .adv     (adv),
    .in_data (s_axis_tdata),
    .thr     (thr),
    .a_out   (f_a),
    .cabs    (f_cabs),
    .cneg    (f_cneg),
    .dmag    (f_dmag),
    .dneg    (f_dneg),
    .sing    (f_sing)
  );

  // lane k gives out[i][j] from the transposed cofactor [j][i]
  for (genvar k = 0; k < N_EL; k++) begin : g_lane
    localparam int SRC = (k % 3) * 3 + (k / 3);
    mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .adv  (adv),
      .cabs (f_cabs[SRC]),
      .cneg (f_cneg[SRC]),
      .dmag (f_dmag),
      .dneg (f_dneg),
      .res  (res[k])
    );
  end

  // input matrix and singular flag ride alongside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_a[0] <= f_a;
      sb_s[0] <= f_sing;
      for (int k = 1; k < LANE_LAT; k++) begin
        sb_a[k] <= sb_a[k-1];
        sb_s[k] <= sb_s[k-1];
      end
    end
  end

  // merge: singular matrices come back unchanged
  always_comb begin
    x_valid = vld[TOT_LAT-1] && adv;
    for (int k = 0; k < N_EL; k++) begin
      x_data[k*DATA_W +: DATA_W] = sb_s[LANE_LAT-1] ? sb_a[LANE_LAT-1][k] : res[k];
    end
  end

  // output register with one-item skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        out_user   <= skid_user;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= x_valid;
        if (x_valid) begin
          out_data <= x_data;
          out_user <= sb_s[LANE_LAT-1];
        end
      end
    end else if (x_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= x_data;
      skid_user  <= sb_s[LANE_LAT-1];
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_user;

endmodule

// ===== hw/rtl/mi3_front.sv =====
// Front pipeline: cofactors, exact determinant, singular test.
// Depends on mi3_pkg.
module mi3_front #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [mi3_pkg::TDATA_W-1:0]  in_data,
  input  mi3_pkg::thr_t                thr,
  output mi3_pkg::elem_t               a_out [mi3_pkg::N_EL],
  output mi3_pkg::cabs_t               cabs  [mi3_pkg::N_EL],
  output logic                         cneg  [mi3_pkg::N_EL],
  output mi3_pkg::dmag_t               dmag,
  output logic                         dneg,
  output logic                         sing
);
  import mi3_pkg::*;

  elem_t a0 [N_EL];
  elem_t a1 [N_EL];
  elem_t a2 [N_EL];
  elem_t a3 [N_EL];
  elem_t a4 [N_EL];
  prod_t pp [N_EL];
  prod_t pn [N_EL];
  cof_t  cof2 [N_EL];
  cof_t  cof3 [N_EL];
  cof_t  cof4 [N_EL];
  logic signed [DATA_W+SPLIT:0] pl [3];
  prod_t ph [3];
  det_t  det;
  det_t  det_sum;
  logic [DET_W-1:0] adet;
  dmag_t thr_s;

  // S0: input register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_EL; k++) a0[k] <= in_data[k*DATA_W +: DATA_W];
    end
  end

  // S1: the two 2x2 minor products of each cofactor
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp[i*3+j] <= a0[OTHER_IDX[i][0]*3 + OTHER_IDX[j][0]]
                     * a0[OTHER_IDX[i][1]*3 + OTHER_IDX[j][1]];
          pn[i*3+j] <= a0[OTHER_IDX[i][1]*3 + OTHER_IDX[j][0]]
                     * a0[OTHER_IDX[i][0]*3 + OTHER_IDX[j][1]];
        end
      end
      a1 <= a0;
    end
  end

  // S2: signed cofactors
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_EL; k++) begin
        if (((k / 3) + (k % 3)) % 2 == 1) cof2[k] <= cof_t'(pn[k]) - cof_t'(pp[k]);
        else                              cof2[k] <= cof_t'(pp[k]) - cof_t'(pn[k]);
      end
      a2 <= a1;
    end
  end

  // S3: row-0 expansion, each product cut into two ~32x33 parts
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        pl[j] <= a2[j] * $signed({1'b0, cof2[j][SPLIT-1:0]});
        ph[j] <= a2[j] * $signed(cof2[j][COF_W-1:SPLIT]);
      end
      cof3 <= cof2;
      a3   <= a2;
    end
  end

  // S4: determinant
  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (det_t'(ph[j]) <<< SPLIT) + det_t'(pl[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det  <= det_sum;
      cof4 <= cof3;
      a4   <= a3;
    end
  end

  // S5: magnitudes and singular test against threshold at 3F scale
  always_comb begin
    adet  = det[DET_W-1] ? det_t'(-det) : det;
    thr_s = dmag_t'(thr) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dneg <= det[DET_W-1];
      dmag <= adet[DMAG_W-1:0];
      sing <= (adet == '0) || (adet[DMAG_W-1:0] < thr_s);
      for (int k = 0; k < N_EL; k++) begin
        cneg[k] <= cof4[k][COF_W-1];
        cabs[k] <= cof4[k][COF_W-1] ? CABS_W'(-cof4[k]) : CABS_W'(cof4[k]);
      end
      a_out <= a4;
    end
  end

endmodule

// ===== hw/rtl/mi3_div_lane.sv =====
// One division lane: |cof|/|det| by pipelined restoring division, rounded, signed and saturated.
// Depends on mi3_pkg.
module mi3_div_lane #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            adv,
  input  mi3_pkg::cabs_t  cabs,
  input  logic            cneg,
  input  mi3_pkg::dmag_t  dmag,
  input  logic            dneg,
  output mi3_pkg::elem_t  res
);
  import mi3_pkg::*;

  localparam int NUM_W = CABS_W + 2 * FRAC_BITS + 2;
  localparam int DEN_W = DMAG_W + 1;
  localparam int R_W   = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  logic [NUM_W-1:0] num_a;
  logic [DEN_W-1:0] den_a;
  logic             neg_a;
  logic [R_W-1:0]   rem   [QB+1];
  logic [DEN_W-1:0] den_s [QB+1];
  quo_t             qv    [QB+1];
  logic             ovf   [QB+1];
  logic             neg_s [QB+1];
  quo_t             qf;

  // numerator carries the half-divisor for round to nearest
  always_ff @(posedge clk) begin
    if (adv) begin
      num_a <= (NUM_W'(cabs) << (2 * FRAC_BITS + 1)) + NUM_W'(dmag);
      den_a <= {dmag, 1'b0};
      neg_a <= cneg ^ dneg;
    end
  end

  // quotient too wide for the kept bits: saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]   <= R_W'(num_a);
      ovf[0]   <= R_W'(num_a) >= (R_W'(den_a) << QB);
      den_s[0] <= den_a;
      neg_s[0] <= neg_a;
      qv[0]    <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int I = QB - 1 - k;
    logic [R_W-1:0] dsh;
    logic [R_W:0]   trial;

    always_comb begin
      dsh   = R_W'(den_s[k]) << I;
      trial = {1'b0, rem[k]} - {1'b0, dsh};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!trial[R_W]) begin
          rem[k+1] <= trial[R_W-1:0];
          qv[k+1]  <= qv[k] | (quo_t'(1) << I);
        end else begin
          rem[k+1] <= rem[k];
          qv[k+1]  <= qv[k];
        end
        den_s[k+1] <= den_s[k];
        ovf[k+1]   <= ovf[k];
        neg_s[k+1] <= neg_s[k];
      end
    end
  end

  assign qf = qv[QB];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (neg_s[QB]) begin
        if (ovf[QB] || qf > quo_t'(33'h0_8000_0000)) res <= elem_t'(32'h8000_0000);
        else                                         res <= elem_t'(~qf[DATA_W-1:0] + 1'b1);
      end else begin
        if (ovf[QB] || qf > quo_t'(33'h0_7FFF_FFFF)) res <= elem_t'(32'h7FFF_FFFF);
        else                                         res <= elem_t'(qf[DATA_W-1:0]);
      end
    end
  end

endmodule

// ===== hw/rtl/mi3_checker.sv =====
// Port-level checks for matrix3_inverse, bound to the top level.
// Depends on mi3_pkg and matrix3_inverse_defines.svh.
`include "matrix3_inverse_defines.svh"

module mi3_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [mi3_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                  m_axis_tuser
);
  import mi3_pkg::*;

  // held result keeps its payload
  `MI3_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // reset empties output and skid
  `MI3_ASSERT_RST(a_rst_clear, rst, !m_axis_tvalid && s_axis_tready)
  // input backpressure only with a stalled, valid output
  `MI3_ASSERT_IMP(a_bp_cause, !s_axis_tready, m_axis_tvalid && !$past(m_axis_tready))

endmodule

bind matrix3_inverse mi3_checker u_mi3_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
// Testbench for matrix3_inverse: random and directed 3x3 matrices checked
// against an in-bench adjugate predictor. Depends on mi3_pkg and the RTL top.
module tb;
  import mi3_pkg::*;

  localparam int LIMIT = 300000;

  typedef struct {
    elem_t el [N_EL];
    bit    sing;
  } inverse_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [DATA_W-1:0]   cfg_data = '0;

  inverse_t    inverse_q [$];
  thr_t        cur_thr = 1;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sink_wait = 0;
  bit          quiet = 0;      // no idling on either side while set

  matrix3_inverse dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adjugate inverse, exact cofactors and determinant, rounded and saturated
  function automatic inverse_t invert(input elem_t m [N_EL], input thr_t thr);
    inverse_t             res;
    logic signed [127:0]  a [N_EL];
    logic signed [127:0]  cof [3][3];
    logic signed [127:0]  det, t;
    logic [127:0]         dmag, cmag, thr_s;
    logic [129:0]         num, q;
    bit                   negres;
    int                   r0, r1, c0, c1;
    for (int k = 0; k < N_EL; k++) a[k] = m[k];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = OTHER_IDX[i][0]; r1 = OTHER_IDX[i][1];
        c0 = OTHER_IDX[j][0]; c1 = OTHER_IDX[j][1];
        t = a[r0*3+c0] * a[r1*3+c1] - a[r1*3+c0] * a[r0*3+c1];
        cof[i][j] = ((i + j) % 2 == 1) ? -t : t;
      end
    end
    det = a[0] * cof[0][0] + a[1] * cof[0][1] + a[2] * cof[0][2];
    dmag = $unsigned(det < 0 ? -det : det);
    thr_s = {96'b0, thr} << (2 * FRAC_BITS_DEF);
    if (dmag == 0 || dmag < thr_s) begin
      res.el = m;
      res.sing = 1;
      return res;
    end
    res.sing = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t = cof[j][i];
        negres = (t < 0) != (det < 0);
        cmag = $unsigned(t < 0 ? -t : t);
        num = ({2'b0, cmag} << (2 * FRAC_BITS_DEF + 1)) + {2'b0, dmag};
        q = num / ({2'b0, dmag} << 1);
        if (negres)
          res.el[i*3+j] = (q > 130'h80000000) ? 32'h80000000 : -q[31:0];
        else
          res.el[i*3+j] = (q > 130'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      end
    end
    return res;
  endfunction

  // sink: draw a stall per item, ready changes at the falling edge
  always @(negedge clk) begin
    if (sink_wait > 0 && !quiet) begin
      m_axis_tready <= 1'b0;
      sink_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    inverse_t exp_r;
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sink_wait = $urandom_range(0, 5);
      if (inverse_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        exp_r = inverse_q.pop_front();
        for (int k = 0; k < N_EL; k++) begin
          if (m_axis_tdata[32*k +: 32] !== exp_r.el[k]) begin
            $error("out_r%0dc%0d expected %h actual %h", k / 3, k % 3,
                   exp_r.el[k], m_axis_tdata[32*k +: 32]);
            errors++;
          end
        end
        if (m_axis_tuser[0] !== exp_r.sing) begin
          $error("singular expected %b actual %b", exp_r.sing, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // one matrix item; called and returns at a falling edge
  task automatic send_matrix(input elem_t m [N_EL]);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    for (int k = 0; k < N_EL; k++) s_axis_tdata[32*k +: 32] <= m[k];
    do @(posedge clk); while (!s_axis_tready);
    inverse_q.push_back(invert(m, cur_thr));
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (inverse_q.size() != 0) @(negedge clk);
  endtask

  // threshold write, only with the block idle
  task automatic set_threshold(input thr_t v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cur_thr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_diag(input elem_t d0, input elem_t d1, input elem_t d2);
    elem_t m [N_EL];
    m = '{d0, 0, 0, 0, d1, 0, 0, 0, d2};
    send_matrix(m);
  endtask

  task automatic send_fill(input elem_t v);
    elem_t m [N_EL];
    foreach (m[k]) m[k] = v;
    send_matrix(m);
  endtask

  task automatic test_directed;
    elem_t m [N_EL];
    send_diag(32'h10000, 32'h10000, 32'h10000);     // identity
    send_diag(-32'sh10000, 32'h20000, 32'h8000);    // negative det
    send_fill(0);                                   // zero det
    send_fill(32'h7FFFFFFF);                        // rank one
    send_fill(32'h80000000);
    send_diag(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_diag(32'h80000000, 32'h80000000, 32'h80000000);
    send_diag(32'h80000000, 32'h7FFFFFFF, -32'sh1);
    send_diag(1, 1, 1);                             // below threshold 1
    send_diag(32'h100, 32'h100, 32'h100);
    m = '{32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 32'h7FFFFFFF, 1,
          0, 1, 32'h7FFFFFFF};
    send_matrix(m);
    m = '{3, 1, 0, 0, 3, 0, 0, 0, 1};               // tie-heavy small quotients
    send_matrix(m);
    set_threshold(0);                               // tiny det now inverted: saturation
    send_diag(1, 1, 1);
    send_diag(-1, 1, 1);
    send_diag(1, 32'h10000, 32'h10000);
    send_fill(0);                                   // zero det stays singular
    m = '{2, 1, 0, 1, 2, 1, 0, 1, 2};
    send_matrix(m);
    set_threshold(32'hFFFFFFFF);
    send_diag(32'h10000, 32'h10000, 32'h10000);
    send_diag(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_diag(32'h80000000, 32'h80000000, 32'h80000000);
  endtask

  // elements of small magnitude so the inverse mostly stays in range
  function automatic elem_t small_elem;
    int sh;
    sh = $urandom_range(4, 20);
    return $signed($urandom() & ((32'h1 << sh) - 1)) - $signed(32'h1 << (sh - 1));
  endfunction

  task automatic test_random(input int n);
    elem_t m [N_EL];
    int    kind, rr, rs;
    for (int it = 0; it < n; it++) begin
      kind = $urandom_range(0, 9);
      foreach (m[k]) m[k] = (kind < 3) ? $urandom() : small_elem();
      if (kind == 9) begin
        // nearly singular: one row copied from another, then nudged
        rr = $urandom_range(0, 2);
        rs = (rr + 1) % 3;
        for (int c = 0; c < 3; c++)
          m[rs*3+c] = m[rr*3+c] + $signed($urandom_range(0, 2)) - 1;
      end
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    set_threshold(1);
    test_random(450);
    set_threshold($urandom_range(0, 255));
    quiet = 1;
    test_random(200);
    quiet = 0;
    set_threshold($urandom());
    test_random(400);
    set_threshold(0);
    test_random(350);
    set_threshold(32'hFFFFFFFF);
    test_random(350);
    drain();
    repeat (60) @(negedge clk);
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_front.sv
hw/rtl/mi3_div_lane.sv
hw/rtl/matrix3_inverse.sv
hw/rtl/mi3_checker.sv
tb/tb.sv
